FILE: rtl/lobm_pkg.sv
// Package for the limit order book matcher.
// Holds the command, store entry and result word types, and the codes.
// Used by every module in rtl/ except lobm_ram.
package lobm_pkg;

  // Most trades that one add may emit
  localparam int unsigned RESULT_CAP = 64;
  localparam int unsigned CAP_W      = 7;

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_CANCEL = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    KIND_ADDED     = 3'd0,
    KIND_TRADE     = 3'd1,
    KIND_CANCELLED = 3'd2,
    KIND_NOT_FOUND = 3'd3,
    KIND_REJECTED  = 3'd4
  } kind_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] id;
    logic [31:0] price;
    logic [31:0] qty;
    logic        sell;
  } cmd_t;

  typedef struct packed {
    logic        vld;
    logic        sell;
    logic [31:0] id;
    logic [31:0] price;
    logic [31:0] qty;
    logic [31:0] stamp;
  } ent_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] maker_id;
    logic [31:0] taker_id;
    logic [31:0] trade_price;
    logic [31:0] fill_qty;
    logic        last;
    logic        bid_present;
    logic [31:0] best_bid_price;
    logic [31:0] best_bid_total;
    logic        ask_present;
    logic [31:0] best_ask_price;
    logic [31:0] best_ask_total;
  } res_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_WR_CANCEL,
    ST_WR_NEW,
    ST_TRADE,
    ST_WR_ASK,
    ST_WR_BID,
    ST_LAST
  } st_t;

  typedef enum logic [1:0] {
    MD_CANCEL,
    MD_FREE,
    MD_BEST,
    MD_TOTAL
  } mode_t;

endpackage

FILE: rtl/limit_order_book_matcher_core.sv
// Price-time limit order book matcher. Each command scans the store one
// entry a cycle through the single read port: a cancel takes 3 passes,
// an add 3 passes, plus 1 pass per trade.
// Commands queue two deep in front; results queue four deep at the output.
// After reset every store entry is cleared while full is held high.
module limit_order_book_matcher_core
  import lobm_pkg::*;
#(
  parameter int unsigned MAX_ORDERS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        op,
  input  logic [31:0] order_id,
  input  logic [31:0] limit_price,
  input  logic [31:0] order_qty,
  input  logic        is_sell,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  kind,
  output logic [31:0] maker_id,
  output logic [31:0] taker_id,
  output logic [31:0] trade_price,
  output logic [31:0] fill_qty,
  output logic        last,
  output logic        bid_present,
  output logic [31:0] best_bid_price,
  output logic [31:0] best_bid_total,
  output logic        ask_present,
  output logic [31:0] best_ask_price,
  output logic [31:0] best_ask_total
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  logic res_push;
  res_t res_in;
  logic res_full;
  res_t res_out;
  logic clearing;

  lobm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .op         (op),
    .order_id   (order_id),
    .limit_price(limit_price),
    .order_qty  (order_qty),
    .is_sell    (is_sell),
    .hold       (clearing),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  lobm_engine #(.N(MAX_ORDERS)) u_engine (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res_in),
    .clearing (clearing)
  );

  lobm_resq u_resq (
    .clk  (clk),
    .rst  (rst),
    .wr   (res_push),
    .din  (res_in),
    .wfull(res_full),
    .pop  (pop),
    .empty(empty),
    .dout (res_out)
  );

  // result word onto ports
  assign kind           = res_out.kind;
  assign maker_id       = res_out.maker_id;
  assign taker_id       = res_out.taker_id;
  assign trade_price    = res_out.trade_price;
  assign fill_qty       = res_out.fill_qty;
  assign last           = res_out.last;
  assign bid_present    = res_out.bid_present;
  assign best_bid_price = res_out.best_bid_price;
  assign best_bid_total = res_out.best_bid_total;
  assign ask_present    = res_out.ask_present;
  assign best_ask_price = res_out.best_ask_price;
  assign best_ask_total = res_out.best_ask_total;

endmodule

FILE: rtl/lobm_ram.sv
// Generic single write port RAM with one registered read port.
// No dependencies.
module lobm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/lobm_front.sv
// Front end: takes input words, drops zero quantity adds, and queues
// commands for the engine. Depends on lobm_pkg.
module lobm_front
  import lobm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        op,
  input  logic [31:0] order_id,
  input  logic [31:0] limit_price,
  input  logic [31:0] order_qty,
  input  logic        is_sell,
  input  logic        hold,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_pop
);

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       acc;
  logic       enq;

  // accept unless queue full or store still clearing
  assign full = (count == 2'd2) || hold;
  assign acc  = push && !full;
  assign enq  = acc && !((op_t'(op) == OP_ADD) && (order_qty == 32'd0));

  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];

  // command queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (enq) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, enq} - {1'b0, cmd_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q[wr_ptr] <= '{op: op_t'(op), id: order_id, price: limit_price,
                     qty: order_qty, sell: is_sell};
    end
  end

endmodule

FILE: rtl/lobm_resq.sv
// Result queue between the engine and the result ports.
// Depends on lobm_pkg.
module lobm_resq
  import lobm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  res_t din,
  output logic wfull,
  input  logic pop,
  output logic empty,
  output res_t dout
);

  res_t       q [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       deq;

  assign wfull = (count == 3'd4);
  assign empty = (count == 3'd0);
  assign deq   = pop && !empty;
  assign dout  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (deq) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + {2'b0, wr} - {2'b0, deq};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q[wr_ptr] <= din;
    end
  end

endmodule

FILE: rtl/lobm_engine.sv
// Matching engine: sequencer that scans the order store one entry a cycle
// for free slots, cancel hits, best prices and level totals, and trades.
// Depends on lobm_pkg and lobm_ram.
module lobm_engine
  import lobm_pkg::*;
#(
  parameter int unsigned N = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  input  logic res_full,
  output logic res_push,
  output res_t res,
  output logic clearing
);

  localparam int unsigned AW = $clog2(N);
  localparam int unsigned CW = $clog2(N + 1);
  localparam int unsigned EW = $bits(ent_t);

  st_t   state;
  st_t   state_next;
  mode_t mode;

  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [EW-1:0] rdata;
  logic          we;
  ent_t          e;

  cmd_t        c;
  logic [31:0] arrival;
  logic [CAP_W-1:0] trade_cnt;
  logic        matching;

  logic          hit_f;
  logic [AW-1:0] hit_idx;
  logic [31:0]   hit_stamp;
  logic          free_f;
  logic [AW-1:0] free_idx;

  logic          bid_f;
  logic [AW-1:0] bid_idx;
  logic [31:0]   bid_id;
  logic [31:0]   bid_price;
  logic [31:0]   bid_qty;
  logic [31:0]   bid_stamp;
  logic [31:0]   bid_tot;
  logic          ask_f;
  logic [AW-1:0] ask_idx;
  logic [31:0]   ask_id;
  logic [31:0]   ask_price;
  logic [31:0]   ask_qty;
  logic [31:0]   ask_stamp;
  logic [31:0]   ask_tot;

  logic        pend_valid;
  kind_t       pend_kind;
  logic [31:0] pend_maker;
  logic [31:0] pend_taker;
  logic [31:0] pend_price;
  logic [31:0] pend_fill;

  logic        crossed;
  logic        bid_better;
  logic        ask_better;
  logic [31:0] fill;
  logic [32:0] bid_sum;
  logic [32:0] ask_sum;

  // order store
  lobm_ram #(.WIDTH(EW), .DEPTH(N)) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign e      = ent_t'(rdata);
  assign cnt_m1 = cnt - CW'(1);
  assign raddr  = (cnt < CW'(N)) ? cnt[AW-1:0] : '0;

  // scan compare logic
  assign bid_better = !bid_f || ((e.price != bid_price) ? (e.price > bid_price)
                                                        : (e.stamp < bid_stamp));
  assign ask_better = !ask_f || ((e.price != ask_price) ? (e.price < ask_price)
                                                        : (e.stamp < ask_stamp));
  assign crossed  = bid_f && ask_f && (bid_price >= ask_price);
  assign fill     = (bid_qty < ask_qty) ? bid_qty : ask_qty;
  assign bid_sum  = {1'b0, bid_tot} + {1'b0, e.qty};
  assign ask_sum  = {1'b0, ask_tot} + {1'b0, e.qty};
  assign clearing = (state == ST_CLEAR);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (cnt == CW'(N - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt == CW'(N)) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        case (mode)
          MD_CANCEL: state_next = hit_f ? ST_WR_CANCEL : ST_SCAN;
          MD_FREE:   state_next = free_f ? ST_WR_NEW : ST_SCAN;
          MD_BEST: begin
            if (matching && crossed && (trade_cnt < CAP_W'(RESULT_CAP))) begin
              state_next = ST_TRADE;
            end else begin
              state_next = ST_SCAN;
            end
          end
          MD_TOTAL:  state_next = ST_LAST;
          default:   state_next = ST_IDLE;
        endcase
      end
      ST_WR_CANCEL: state_next = ST_SCAN;
      ST_WR_NEW:    state_next = ST_SCAN;
      ST_TRADE: begin
        if (!(pend_valid && res_full)) begin
          state_next = ST_WR_ASK;
        end
      end
      ST_WR_ASK: state_next = ST_WR_BID;
      ST_WR_BID: state_next = ST_SCAN;
      ST_LAST: begin
        if (!res_full) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs: store writes, command pop, result pushes
  always_comb begin
    we       = 1'b0;
    waddr    = '0;
    wdata    = '0;
    cmd_pop  = 1'b0;
    res_push = 1'b0;
    res      = '0;
    case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = cnt[AW-1:0];
      end
      ST_IDLE: begin
        cmd_pop = cmd_valid;
      end
      ST_WR_CANCEL: begin
        we    = 1'b1;
        waddr = hit_idx;
      end
      ST_WR_NEW: begin
        we    = 1'b1;
        waddr = free_idx;
        wdata = {1'b1, c.sell, c.id, c.price, c.qty, arrival};
      end
      ST_WR_ASK: begin
        we    = 1'b1;
        waddr = ask_idx;
        wdata = {(ask_qty != 32'd0), 1'b1, ask_id, ask_price, ask_qty, ask_stamp};
      end
      ST_WR_BID: begin
        we    = 1'b1;
        waddr = bid_idx;
        wdata = {(bid_qty != 32'd0), 1'b0, bid_id, bid_price, bid_qty, bid_stamp};
      end
      ST_TRADE: begin
        // earlier trade goes out once a further one is known
        res_push         = pend_valid && !res_full;
        res.kind         = pend_kind;
        res.maker_id     = pend_maker;
        res.taker_id     = pend_taker;
        res.trade_price  = pend_price;
        res.fill_qty     = pend_fill;
      end
      ST_LAST: begin
        res_push           = !res_full;
        res.kind           = pend_kind;
        res.maker_id       = pend_maker;
        res.taker_id       = pend_taker;
        res.trade_price    = pend_price;
        res.fill_qty       = pend_fill;
        res.last           = 1'b1;
        res.bid_present    = bid_f;
        res.best_bid_price = bid_f ? bid_price : 32'd0;
        res.best_bid_total = bid_f ? bid_tot : 32'd0;
        res.ask_present    = ask_f;
        res.best_ask_price = ask_f ? ask_price : 32'd0;
        res.best_ask_total = ask_f ? ask_tot : 32'd0;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      cnt        <= '0;
      arrival    <= 32'd0;
      trade_cnt  <= '0;
      pend_valid <= 1'b0;
      matching   <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_CLEAR: begin
          cnt <= (cnt == CW'(N - 1)) ? '0 : cnt + CW'(1);
        end
        ST_IDLE: begin
          cnt        <= '0;
          trade_cnt  <= '0;
          pend_valid <= 1'b0;
          matching   <= 1'b0;
        end
        ST_SCAN: begin
          cnt <= cnt + CW'(1);
        end
        ST_DECIDE: begin
          cnt <= '0;
          if (mode == MD_FREE && free_f) begin
            matching <= 1'b1;
          end
        end
        ST_WR_NEW: begin
          arrival <= arrival + 32'd1;
        end
        ST_TRADE: begin
          if (!(pend_valid && res_full)) begin
            pend_valid <= 1'b1;
          end
        end
        ST_WR_BID: begin
          trade_cnt <= trade_cnt + CAP_W'(1);
          cnt       <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // scan and trade datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        c          <= cmd;
        hit_f      <= 1'b0;
        free_f     <= 1'b0;
        mode       <= (cmd.op == OP_CANCEL) ? MD_CANCEL : MD_FREE;
        pend_kind  <= KIND_ADDED;
        pend_maker <= 32'd0;
        pend_taker <= 32'd0;
        pend_price <= 32'd0;
        pend_fill  <= 32'd0;
      end
      ST_SCAN: begin
        if (cnt != '0) begin
          case (mode)
            MD_CANCEL: begin
              if (e.vld && e.id == c.id && (!hit_f || e.stamp < hit_stamp)) begin
                hit_f     <= 1'b1;
                hit_idx   <= cnt_m1[AW-1:0];
                hit_stamp <= e.stamp;
              end
            end
            MD_FREE: begin
              if (!free_f && !e.vld) begin
                free_f   <= 1'b1;
                free_idx <= cnt_m1[AW-1:0];
              end
            end
            MD_BEST: begin
              if (e.vld && !e.sell && bid_better) begin
                bid_f     <= 1'b1;
                bid_idx   <= cnt_m1[AW-1:0];
                bid_id    <= e.id;
                bid_price <= e.price;
                bid_qty   <= e.qty;
                bid_stamp <= e.stamp;
              end
              if (e.vld && e.sell && ask_better) begin
                ask_f     <= 1'b1;
                ask_idx   <= cnt_m1[AW-1:0];
                ask_id    <= e.id;
                ask_price <= e.price;
                ask_qty   <= e.qty;
                ask_stamp <= e.stamp;
              end
            end
            MD_TOTAL: begin
              if (e.vld && !e.sell && bid_f && e.price == bid_price) begin
                bid_tot <= bid_sum[32] ? 32'hFFFF_FFFF : bid_sum[31:0];
              end
              if (e.vld && e.sell && ask_f && e.price == ask_price) begin
                ask_tot <= ask_sum[32] ? 32'hFFFF_FFFF : ask_sum[31:0];
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DECIDE: begin
        case (mode)
          MD_CANCEL: begin
            pend_kind <= hit_f ? KIND_CANCELLED : KIND_NOT_FOUND;
            mode      <= MD_BEST;
            bid_f     <= 1'b0;
            ask_f     <= 1'b0;
          end
          MD_FREE: begin
            pend_kind <= free_f ? KIND_ADDED : KIND_REJECTED;
            mode      <= MD_BEST;
            bid_f     <= 1'b0;
            ask_f     <= 1'b0;
          end
          MD_BEST: begin
            if (!(matching && crossed && (trade_cnt < CAP_W'(RESULT_CAP)))) begin
              mode    <= MD_TOTAL;
              bid_tot <= 32'd0;
              ask_tot <= 32'd0;
            end
          end
          default: begin
          end
        endcase
      end
      ST_TRADE: begin
        if (!(pend_valid && res_full)) begin
          pend_kind <= KIND_TRADE;
          pend_fill <= fill;
          bid_qty   <= bid_qty - fill;
          ask_qty   <= ask_qty - fill;
          if (bid_id < ask_id) begin
            pend_maker <= bid_id;
            pend_taker <= ask_id;
            pend_price <= bid_price;
          end else begin
            pend_maker <= ask_id;
            pend_taker <= bid_id;
            pend_price <= ask_price;
          end
        end
      end
      ST_WR_BID: begin
        bid_f <= 1'b0;
        ask_f <= 1'b0;
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full) else $error("result pushed into full queue");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> (state == ST_IDLE && cmd_valid)) else $error("pop outside idle");
  a_cap: assert property (@(posedge clk) disable iff (rst)
    trade_cnt <= CAP_W'(RESULT_CAP)) else $error("trade count past cap");
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!res_push && !cmd_pop)) else $error("activity during clear");
`endif

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the limit order book matcher core.
// Needs lobm_pkg and limit_order_book_matcher_core from rtl/; predicts every
// result word from its own copy of the order store and checks them in order.
module tb_top;
  import lobm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = 64;
  localparam int IDLE_LIMIT = 30000;
  localparam int N_RANDOM   = 170;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic        op;
  logic [31:0] order_id;
  logic [31:0] limit_price;
  logic [31:0] order_qty;
  logic        is_sell;
  logic        empty;
  logic        pop;
  logic [2:0]  kind;
  logic [31:0] maker_id;
  logic [31:0] taker_id;
  logic [31:0] trade_price;
  logic [31:0] fill_qty;
  logic        last;
  logic        bid_present;
  logic [31:0] best_bid_price;
  logic [31:0] best_bid_total;
  logic        ask_present;
  logic [31:0] best_ask_price;
  logic [31:0] best_ask_total;

  limit_order_book_matcher_core #(.MAX_ORDERS(DEPTH)) DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .op(op),
    .order_id(order_id), .limit_price(limit_price), .order_qty(order_qty),
    .is_sell(is_sell), .empty(empty), .pop(pop), .kind(kind),
    .maker_id(maker_id), .taker_id(taker_id), .trade_price(trade_price),
    .fill_qty(fill_qty), .last(last), .bid_present(bid_present),
    .best_bid_price(best_bid_price), .best_bid_total(best_bid_total),
    .ask_present(ask_present), .best_ask_price(best_ask_price),
    .best_ask_total(best_ask_total)
  );

  // Shadow order book
  logic        book_valid [DEPTH];
  logic [31:0] book_id    [DEPTH];
  logic [31:0] book_price [DEPTH];
  logic [31:0] book_qty   [DEPTH];
  logic [31:0] book_stamp [DEPTH];
  logic        book_sell  [DEPTH];
  logic [31:0] next_stamp;
  logic [31:0] missed_cancels;

  res_t expected_words[$];
  int   error_count;
  int   orders_sent;
  int   words_checked;
  int   trades_checked;
  int   idle_cycles;
  int   burst_left;
  int   next_order_id;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Best resting order of one side, -1 when the side is empty
  function automatic int best_slot(input logic sell);
    int best;
    logic better;
    best = -1;
    for (int i = 0; i < DEPTH; i++) begin
      if (book_valid[i] && book_sell[i] == sell) begin
        if (best < 0) begin
          best = i;
        end else begin
          if (book_price[i] != book_price[best])
            better = sell ? (book_price[i] < book_price[best])
                          : (book_price[i] > book_price[best]);
          else
            better = book_stamp[i] < book_stamp[best];
          if (better) best = i;
        end
      end
    end
    return best;
  endfunction

  // Saturating quantity at one price level
  function automatic logic [31:0] level_sum(input logic sell, input logic [31:0] price);
    logic [32:0] sum;
    sum = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (book_valid[i] && book_sell[i] == sell && book_price[i] == price) begin
        sum = sum + book_qty[i];
        if (sum > 33'hFFFF_FFFF) sum = 33'hFFFF_FFFF;
      end
    end
    return sum[31:0];
  endfunction

  function automatic res_t plain_word(input kind_t k);
    res_t w;
    w = '0;
    w.kind = k;
    return w;
  endfunction

  // Works out the result words of one accepted order and queues them
  task automatic predict_order(input logic o, input logic [31:0] id,
                               input logic [31:0] price, input logic [31:0] qty,
                               input logic sell);
    int   hit;
    int   slot;
    int   b;
    int   a;
    res_t w;
    res_t batch[$];
    logic [31:0] fill;
    if (o == OP_CANCEL) begin
      hit = -1;
      for (int i = 0; i < DEPTH; i++)
        if (book_valid[i] && book_id[i] == id &&
            (hit < 0 || book_stamp[i] < book_stamp[hit])) hit = i;
      if (hit >= 0) begin
        book_valid[hit] = 1'b0;
        batch.push_back(plain_word(KIND_CANCELLED));
      end else begin
        missed_cancels = missed_cancels + 32'd1;
        batch.push_back(plain_word(KIND_NOT_FOUND));
      end
    end else if (qty != 0) begin
      slot = -1;
      for (int i = 0; i < DEPTH && slot < 0; i++)
        if (!book_valid[i]) slot = i;
      if (slot < 0) begin
        batch.push_back(plain_word(KIND_REJECTED));
      end else begin
        book_valid[slot] = 1'b1;
        book_id[slot]    = id;
        book_price[slot] = price;
        book_qty[slot]   = qty;
        book_stamp[slot] = next_stamp;
        book_sell[slot]  = sell;
        next_stamp       = next_stamp + 32'd1;
        // Match while the book is crossed, bounded per add
        while (batch.size() < RESULT_CAP) begin
          b = best_slot(1'b0);
          a = best_slot(1'b1);
          if (b < 0 || a < 0 || book_price[b] < book_price[a]) break;
          fill = (book_qty[b] < book_qty[a]) ? book_qty[b] : book_qty[a];
          w = plain_word(KIND_TRADE);
          w.fill_qty = fill;
          if (book_id[b] < book_id[a]) begin
            w.maker_id = book_id[b]; w.taker_id = book_id[a];
            w.trade_price = book_price[b];
          end else begin
            w.maker_id = book_id[a]; w.taker_id = book_id[b];
            w.trade_price = book_price[a];
          end
          batch.push_back(w);
          book_qty[b] = book_qty[b] - fill;
          book_qty[a] = book_qty[a] - fill;
          if (book_qty[a] == 0) book_valid[a] = 1'b0;
          if (book_qty[b] == 0) book_valid[b] = 1'b0;
        end
        if (batch.size() == 0) batch.push_back(plain_word(KIND_ADDED));
      end
    end
    if (batch.size() > 0) begin
      w = batch.pop_back();
      w.last = 1'b1;
      b = best_slot(1'b0);
      a = best_slot(1'b1);
      if (b >= 0) begin
        w.bid_present = 1'b1;
        w.best_bid_price = book_price[b];
        w.best_bid_total = level_sum(1'b0, book_price[b]);
      end
      if (a >= 0) begin
        w.ask_present = 1'b1;
        w.best_ask_price = book_price[a];
        w.best_ask_total = level_sum(1'b1, book_price[a]);
      end
      batch.push_back(w);
      foreach (batch[i]) expected_words.push_back(batch[i]);
    end
  endtask

  // Sends one order word; bursts with random gaps between them
  task automatic send_order(input logic o, input logic [31:0] id,
                            input logic [31:0] price, input logic [31:0] qty,
                            input logic sell);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    push        <= 1'b1;
    op          <= o;
    order_id    <= id;
    limit_price <= price;
    order_qty   <= qty;
    is_sell     <= sell;
    do @(posedge clk); while (full);
    orders_sent++;
    predict_order(o, id, price, qty, sell);
  endtask

  task automatic enter_order(input logic [31:0] id, input logic [31:0] price,
                             input logic [31:0] qty, input logic sell);
    send_order(OP_ADD, id, price, qty, sell);
  endtask

  task automatic pull_order(input logic [31:0] id);
    send_order(OP_CANCEL, id, $urandom, $urandom, 1'($urandom_range(0, 1)));
  endtask

  // Cancels every resting order so the next test starts empty
  task automatic flush_book();
    logic [31:0] live[$];
    for (int i = 0; i < DEPTH; i++)
      if (book_valid[i]) live.push_back(book_id[i]);
    foreach (live[i]) pull_order(live[i]);
  endtask

  // Field extremes, zero quantity, trade at price zero, missing cancel
  task automatic test_extremes();
    enter_order(32'd10, 32'd0, 32'd1, 1'b0);
    enter_order(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    enter_order(32'd11, 32'd5, 32'd0, 1'b0);
    enter_order(32'd5, 32'd0, 32'd3, 1'b1);
    pull_order(32'hFFFF_FFFF);
    pull_order(32'd12345);
    pull_order(32'd5);
    pull_order(32'd0);
  endtask

  // Level total saturates; equal ids make the ask the maker
  task automatic test_saturation_and_ties();
    enter_order(32'd20, 32'd7, 32'hFFFF_FFFF, 1'b0);
    enter_order(32'd21, 32'd7, 32'hFFFF_FFFF, 1'b0);
    enter_order(32'd30, 32'd7, 32'd1, 1'b1);
    enter_order(32'd60, 32'd90, 32'd2, 1'b0);
    enter_order(32'd60, 32'd80, 32'd3, 1'b1);
    flush_book();
  endtask

  // Duplicate ids: cancel takes the oldest
  task automatic test_duplicate_ids();
    enter_order(32'd40, 32'd50, 32'd4, 1'b0);
    enter_order(32'd40, 32'd50, 32'd9, 1'b0);
    pull_order(32'd40);
    pull_order(32'd40);
    pull_order(32'd40);
  endtask

  // Fill the store, get a reject, then sweep the whole bid side
  task automatic test_full_store();
    for (int i = 0; i < DEPTH; i++) enter_order(32'd100 + i, 32'd1, 32'd1, 1'b0);
    enter_order(32'd999, 32'd1, 32'd1, 1'b1);
    pull_order(32'd100);
    enter_order(32'd1, 32'd0, 32'd100, 1'b1);
    flush_book();
  endtask

  // Mostly well-formed traffic around a narrow price band
  task automatic test_random_traffic();
    int live;
    int pick;
    logic [31:0] id;
    logic [31:0] price;
    logic [31:0] qty;
    for (int n = 0; n < N_RANDOM; n++) begin
      live = 0;
      for (int i = 0; i < DEPTH; i++) live += book_valid[i];
      if ($urandom_range(0, 99) < (live > 56 ? 60 : 25)) begin
        pick = $urandom_range(0, DEPTH - 1);
        id = $urandom;
        if ($urandom_range(0, 4) != 0)
          for (int i = 0; i < DEPTH; i++)
            if (book_valid[(pick + i) % DEPTH]) begin
              id = book_id[(pick + i) % DEPTH];
              break;
            end
        pull_order(id);
      end else begin
        next_order_id++;
        id = ($urandom_range(0, 9) == 0) ? $urandom : next_order_id;
        price = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(100, 115);
        case ($urandom_range(0, 19))
          0:       qty = 32'd0;
          1:       qty = $urandom;
          default: qty = $urandom_range(1, 20);
        endcase
        enter_order(id, price, qty, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Result checker with its own stall pattern
  int          pop_mode;
  logic [31:0] pop_cycle;
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst && pop && !empty) begin
      got.kind = kind_t'(kind);
      got.maker_id = maker_id;             got.taker_id = taker_id;
      got.trade_price = trade_price;       got.fill_qty = fill_qty;
      got.last = last;
      got.bid_present = bid_present;       got.best_bid_price = best_bid_price;
      got.best_bid_total = best_bid_total;
      got.ask_present = ask_present;       got.best_ask_price = best_ask_price;
      got.best_ask_total = best_ask_total;
      words_checked++;
      if (kind == KIND_TRADE) trades_checked++;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word %p", $time, got);
        error_count++;
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected %p", $time, want);
          $display("%0t:          actual   %p", $time, got);
          error_count++;
        end
      end
    end
    pop_cycle <= pop_cycle + 32'd1;
    if (pop_cycle[7:0] == 8'd0) pop_mode <= $urandom_range(0, 2);
    case (pop_mode)
      0:       pop <= 1'b1;
      1:       pop <= 1'($urandom_range(0, 1));
      default: pop <= (pop_cycle[2:0] > 3'd4);
    endcase
  end

  // Watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst = 1'b1; push = 1'b0; op = 1'b0; order_id = '0; limit_price = '0;
    order_qty = '0; is_sell = 1'b0; pop = 1'b0;
    pop_mode = 0; pop_cycle = '0; idle_cycles = 0;
    error_count = 0; orders_sent = 0; words_checked = 0; trades_checked = 0;
    burst_left = 0; next_order_id = 1000; next_stamp = '0; missed_cancels = '0;
    for (int i = 0; i < DEPTH; i++) begin
      book_valid[i] = 1'b0; book_id[i] = '0; book_price[i] = '0;
      book_qty[i] = '0; book_stamp[i] = '0; book_sell[i] = 1'b0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_saturation_and_ties();
    test_duplicate_ids();
    test_full_store();
    test_random_traffic();
    push <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    $display("Sent %0d orders, checked %0d result words including %0d trades,",
             orders_sent, words_checked, trades_checked);
    $display("covering extremes, saturation, duplicate ids, full store and random flow.");
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
